### hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// shared types and constants of the count-min sketch
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

  localparam int KEY_W        = 32;
  localparam int COEF_W       = 24;
  localparam int CNT_W        = 32;
  localparam int NUM_ROW_REGS = 4;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  // hash product and sum widths
  localparam int PROD_W    = KEY_W + COEF_W;
  localparam int HASH_W    = PROD_W + 1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_MAX = '1;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register indexes
  localparam logic [2:0] REG_ROW0_MULT   = 3'd0;
  localparam logic [2:0] REG_ROW0_OFFSET = 3'd4;

  localparam coef_t MULT_RESET [NUM_ROW_REGS] = '{24'd1, 24'd3, 24'd5, 24'd7};
  localparam coef_t OFFS_RESET [NUM_ROW_REGS] = '{24'd0, 24'd11, 24'd13, 24'd17};

endpackage

`default_nettype wire

### hdl/count_min_sketch.sv
// ----------------------------------------------------------------------------
// count_min_sketch
// count-min sketch over 32-bit keys with per-row hash coefficients
// ----------------------------------------------------------------------------
// a query estimate is shown after the word passes the front hash unit, with
//   its two-round reciprocal modulo reducer when ROW_LEN is not a power of two,
//   the queue, and the read and exec states of the back
// the front takes no new word until it has pushed the last one into the queue;
//   the back does a read-modify-write on the row rams for each word
// reset: registers take their reset values; a clearing pass zeroes the counters,
//   and no word is taken until it ends
`default_nettype none

module count_min_sketch #(
  parameter int ROWS    = 4,
  parameter int ROW_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // request words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  cms_pkg::key_t               key,
  // estimate words
  output logic                        out_valid,
  input  logic                        out_stall,
  output cms_pkg::cnt_t               estimate,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cms_pkg::ADDR_W-1:0]  paddr,
  input  logic [cms_pkg::DATA_W-1:0]  pwdata,
  output logic [cms_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import cms_pkg::*;

  localparam int CW          = $clog2(ROW_LEN);
  localparam int QW          = 1 + ROWS * CW;
  localparam int QUEUE_DEPTH = 2;

  // hash coefficients, all four rows are stored regardless of ROWS
  coef_t [NUM_ROW_REGS-1:0] row_mult;
  coef_t [NUM_ROW_REGS-1:0] row_offset;

  logic [2:0]         reg_idx;
  logic               cfg_wr;
  coef_t              rd_val;

  // front to queue
  logic               fq_valid;
  logic               fq_stall;
  logic               fq_req;
  logic [ROWS*CW-1:0] fq_cols;
  // queue to back
  logic               qb_valid;
  logic               qb_stall;
  logic [QW-1:0]      qb_data;
  logic               clearing;

  // ------------------------------------------------------------------------
  // register port: no wait states, index from the word address
  // ------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROW_REGS; r++) begin
        row_mult[r]   <= MULT_RESET[r];
        row_offset[r] <= OFFS_RESET[r];
      end
    end else if (cfg_wr) begin
      // low half of the map holds multipliers, high half offsets
      if (reg_idx < REG_ROW0_OFFSET) begin
        row_mult[reg_idx[1:0]] <= pwdata[COEF_W-1:0];
      end else begin
        row_offset[reg_idx[1:0]] <= pwdata[COEF_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx < REG_ROW0_OFFSET) begin
      rd_val = row_mult[reg_idx[1:0]];
    end else begin
      rd_val = row_offset[reg_idx[1:0]];
    end
    prdata = DATA_W'(rd_val);
  end

  // ------------------------------------------------------------------------
  // front: take the request, hash the key for every row
  // ------------------------------------------------------------------------
  cms_front #(
    .ROWS    (ROWS),
    .ROW_LEN (ROW_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (req_type),
    .in_key   (key),
    .mult     (row_mult),
    .offs     (row_offset),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_req    (fq_req),
    .q_cols   (fq_cols)
  );

  // ------------------------------------------------------------------------
  // queue: request code with its column per row
  // ------------------------------------------------------------------------
  cms_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_data   ({fq_req, fq_cols}),
    .out_valid (qb_valid),
    .out_stall (qb_stall),
    .out_data  (qb_data)
  );

  // ------------------------------------------------------------------------
  // back: counter update or minimum over the rows, estimate register
  // ------------------------------------------------------------------------
  cms_back #(
    .ROWS    (ROWS),
    .ROW_LEN (ROW_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_stall   (qb_stall),
    .q_req     (qb_data[QW-1]),
    .q_cols    (qb_data[QW-2:0]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .estimate  (estimate),
    .clearing  (clearing)
  );

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
  // no request word is taken while the counters are being cleared
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("request taken during clearing pass");

  // no estimate can be pending while the rams are still being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("estimate shown during clearing pass");

  // leaving reset always starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("clearing pass did not start after reset");

  // nothing reaches the back while it is clearing
  a_queue_held_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> qb_stall)
    else $error("queue drained during clearing pass");

endmodule

`default_nettype wire

### hdl/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/cms_front.sv
// ----------------------------------------------------------------------------
// cms_front
// takes request words, hashes the key for every row and reduces mod ROW_LEN
// ----------------------------------------------------------------------------
`default_nettype none

module cms_front #(
  parameter int ROWS    = 4,
  parameter int ROW_LEN = 1024
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         hold,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         in_req,
  input  cms_pkg::key_t                                in_key,
  input  cms_pkg::coef_t [cms_pkg::NUM_ROW_REGS-1:0]   mult,
  input  cms_pkg::coef_t [cms_pkg::NUM_ROW_REGS-1:0]   offs,
  output logic                                         q_valid,
  input  logic                                         q_stall,
  output logic                                         q_req,
  output logic [ROWS*$clog2(ROW_LEN)-1:0]              q_cols
);

  import cms_pkg::*;

  localparam int CW            = $clog2(ROW_LEN);
  localparam bit IS_POW2       = (ROW_LEN & (ROW_LEN - 1)) == 0;

  // modulo reducer: the hash is split into 32-bit halves, each reduced by a
  // reciprocal multiply, the high half folded back with 2^32 mod ROW_LEN,
  // and the folded sum reduced once more
  localparam int LO_W   = 32;
  localparam int RCP_W  = LO_W + 1;
  localparam int SHIFT  = LO_W + CW;
  localparam int FULL_W = LO_W + RCP_W;
  localparam int QUO_W  = FULL_W - SHIFT;
  localparam logic [63:0] RCP_WIDE =
    ((64'd1 << SHIFT) + 64'(ROW_LEN) - 64'd1) / 64'(ROW_LEN);
  localparam logic [RCP_W-1:0] RCP  = RCP_W'(RCP_WIDE);
  localparam logic [LO_W-1:0]  LEN  = LO_W'(ROW_LEN);
  localparam logic [LO_W-1:0]  FOLD = LO_W'((64'd1 << LO_W) % 64'(ROW_LEN));

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_MUL  = 4'd1;
  localparam logic [3:0] F_ADD  = 4'd2;
  localparam logic [3:0] F_QUO1 = 4'd3;
  localparam logic [3:0] F_REM1 = 4'd4;
  localparam logic [3:0] F_FOLD = 4'd5;
  localparam logic [3:0] F_QUO2 = 4'd6;
  localparam logic [3:0] F_REM2 = 4'd7;
  localparam logic [3:0] F_PUSH = 4'd8;

  logic [3:0]        state;
  logic              req;
  key_t              key;
  logic [PROD_W-1:0] prod     [ROWS];
  logic [HASH_W-1:0] hash_sum [ROWS];
  logic [LO_W-1:0]   lo       [ROWS];
  logic [LO_W-1:0]   hi       [ROWS];
  logic [QUO_W-1:0]  lo_quo   [ROWS];
  logic [QUO_W-1:0]  hi_quo   [ROWS];
  logic [LO_W-1:0]   lo_next  [ROWS];
  logic [LO_W-1:0]   hi_next  [ROWS];
  logic [CW-1:0]     rem      [ROWS];

  // floor(x / ROW_LEN), exact for any 32-bit x
  function automatic logic [QUO_W-1:0] quotient(input logic [LO_W-1:0] x);
    logic [FULL_W-1:0] full;
    full = FULL_W'(x) * FULL_W'(RCP);
    return full[FULL_W-1:SHIFT];
  endfunction

  // product plus offset, and what is left after taking out the quotient
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hash_sum[r] = HASH_W'(prod[r]) + HASH_W'(offs[r]);
      lo_next[r]  = lo[r] - LO_W'(lo_quo[r]) * LEN;
      hi_next[r]  = hi[r] - LO_W'(hi_quo[r]) * LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && !in_stall) begin
            req   <= in_req;
            key   <= in_key;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          for (int r = 0; r < ROWS; r++) begin
            prod[r] <= PROD_W'(mult[r]) * PROD_W'(key);
          end
          state <= F_ADD;
        end
        F_ADD: begin
          for (int r = 0; r < ROWS; r++) begin
            rem[r] <= hash_sum[r][CW-1:0];
            lo[r]  <= hash_sum[r][LO_W-1:0];
            hi[r]  <= LO_W'(hash_sum[r][HASH_W-1:LO_W]);
          end
          state <= IS_POW2 ? F_PUSH : F_QUO1;
        end
        F_QUO1: begin
          for (int r = 0; r < ROWS; r++) begin
            lo_quo[r] <= quotient(lo[r]);
            hi_quo[r] <= quotient(hi[r]);
          end
          state <= F_REM1;
        end
        F_REM1: begin
          for (int r = 0; r < ROWS; r++) begin
            lo[r] <= lo_next[r];
            hi[r] <= hi_next[r];
          end
          state <= F_FOLD;
        end
        F_FOLD: begin
          // both halves are below ROW_LEN, so the sum stays under 2^32
          for (int r = 0; r < ROWS; r++) begin
            lo[r] <= hi[r] * FOLD + lo[r];
          end
          state <= F_QUO2;
        end
        F_QUO2: begin
          for (int r = 0; r < ROWS; r++) begin
            lo_quo[r] <= quotient(lo[r]);
          end
          state <= F_REM2;
        end
        F_REM2: begin
          for (int r = 0; r < ROWS; r++) begin
            rem[r] <= lo_next[r][CW-1:0];
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stall) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_stall = hold || (state != F_IDLE);
  assign q_valid  = (state == F_PUSH);
  assign q_req    = req;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      q_cols[r*CW +: CW] = rem[r];
    end
  end

endmodule

`default_nettype wire

### hdl/cms_queue.sv
// ----------------------------------------------------------------------------
// cms_queue
// short word queue between the hash front and the counter back
// ----------------------------------------------------------------------------
`default_nettype none

module cms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push;
  logic             pop;

  assign in_stall  = (count == CNTW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/cms_back.sv
// ----------------------------------------------------------------------------
// cms_back
// row memories: clearing pass, saturating increment and minimum search
// ----------------------------------------------------------------------------
`default_nettype none

module cms_back #(
  parameter int ROWS    = 4,
  parameter int ROW_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_stall,
  input  logic                            q_req,
  input  logic [ROWS*$clog2(ROW_LEN)-1:0] q_cols,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cms_pkg::cnt_t                   estimate,
  output logic                            clearing
);

  import cms_pkg::*;

  localparam int CW                = $clog2(ROW_LEN);
  localparam logic [CW-1:0] ADDR_LAST = CW'(ROW_LEN - 1);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_READ  = 2'd2;
  localparam logic [1:0] B_EXEC  = 2'd3;

  logic [1:0]             state;
  logic [CW-1:0]          clr_addr;
  logic                   req;
  logic [ROWS*CW-1:0]     cols;
  logic                   take;
  logic                   we;
  logic [CW-1:0]          waddr [ROWS];
  cnt_t                   wdata [ROWS];
  logic [CW-1:0]          raddr [ROWS];
  cnt_t                   rdata [ROWS];
  cnt_t                   best;

  assign clearing = (state == B_CLEAR);
  assign take     = (state == B_IDLE) && q_valid && ((q_req == REQ_ADD) || !out_valid);
  assign q_stall  = !((state == B_IDLE) && ((q_req == REQ_ADD) || !out_valid));

  // write side: zeros while clearing, saturating increment for an add
  always_comb begin
    we = clearing || ((state == B_EXEC) && (req == REQ_ADD));
    for (int r = 0; r < ROWS; r++) begin
      raddr[r] = cols[r*CW +: CW];
      if (clearing) begin
        waddr[r] = clr_addr;
        wdata[r] = '0;
      end else begin
        waddr[r] = cols[r*CW +: CW];
        wdata[r] = (rdata[r] == CNT_MAX) ? rdata[r] : rdata[r] + 1'b1;
      end
    end
  end

  always_comb begin
    best = CNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (rdata[r] < best) begin
        best = rdata[r];
      end
    end
  end

  for (genvar g = 0; g < ROWS; g++) begin : g_row
    cms_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ROW_LEN)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr[g]),
      .wdata (wdata[g]),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_LAST) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (take) begin
            req   <= q_req;
            cols  <= q_cols;
            state <= B_READ;
          end
        end
        B_READ: state <= B_EXEC;
        B_EXEC: begin
          if (req == REQ_QUERY) begin
            estimate  <= best;
            out_valid <= 1'b1;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the count-min sketch: request words are driven with
// random pacing, a shadow sketch predicts every query estimate, and the hash
// coefficients are rewritten between traffic phases over the register port
// ----------------------------------------------------------------------------

module tb;
  import cms_pkg::*;

  localparam int ROWS      = 4;
  localparam int ROW_LEN   = 1024;
  localparam int NUM_REGS  = 2 * NUM_ROW_REGS;
  // run guard limit, set above the slowest correct run (clearing pass, hash
  // unit, random gaps and stalls, one long hold-off)
  localparam int CYCLE_LIMIT = 500000;
  // add words give no estimate, so quiet this long before touching registers
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;

  // --------------------------------------------------------------------------
  // shadow sketch: own counters and coefficients, queue of estimates due
  // --------------------------------------------------------------------------
  class sketch_board;
    cnt_t  counters [ROWS][ROW_LEN];
    coef_t row_mult [NUM_ROW_REGS];
    coef_t row_offs [NUM_ROW_REGS];
    cnt_t  estimates_due [$];
    int    mismatches;

    function new();
      for (int r = 0; r < NUM_ROW_REGS; r++) begin
        row_mult[r] = MULT_RESET[r];
        row_offs[r] = OFFS_RESET[r];
      end
      foreach (counters[r, c]) counters[r][c] = '0;
      mismatches = 0;
    endfunction

    // only the low 24 bits of a written word are kept
    function void set_coef(int idx, logic [DATA_W-1:0] data);
      if (idx >= REG_ROW0_OFFSET && idx < NUM_REGS)
        row_offs[idx - REG_ROW0_OFFSET] = data[COEF_W-1:0];
      else if (idx >= REG_ROW0_MULT && idx < REG_ROW0_OFFSET)
        row_mult[idx - REG_ROW0_MULT] = data[COEF_W-1:0];
    endfunction

    function logic [DATA_W-1:0] coef_value(int idx);
      if (idx >= REG_ROW0_OFFSET)
        return DATA_W'(row_offs[idx - REG_ROW0_OFFSET]);
      return DATA_W'(row_mult[idx - REG_ROW0_MULT]);
    endfunction

    // exact 64-bit hash, then reduced to a column
    function int hash_column(int row, key_t k);
      logic [63:0] h;
      h = 64'(row_mult[row]) * 64'(k) + 64'(row_offs[row]);
      return int'(h % 64'(ROW_LEN));
    endfunction

    function void note_word(logic rt, key_t k);
      cnt_t best;
      int   c;
      if (rt == REQ_ADD) begin
        for (int r = 0; r < ROWS; r++) begin
          c = hash_column(r, k);
          if (counters[r][c] != CNT_MAX) counters[r][c]++;
        end
      end else begin
        best = CNT_MAX;
        for (int r = 0; r < ROWS; r++) begin
          c = hash_column(r, k);
          if (counters[r][c] < best) best = counters[r][c];
        end
        estimates_due.push_back(best);
      end
    endfunction

    function void check_estimate(cnt_t actual);
      cnt_t want;
      if (estimates_due.size() == 0) begin
        $display("%0t: estimate mismatch, expected none, got %0d", $time, actual);
        mismatches++;
      end else begin
        want = estimates_due.pop_front();
        if (actual !== want) begin
          $display("%0t: estimate mismatch, expected %0d, got %0d", $time, want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_ADD;
  key_t              key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cnt_t              estimate;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  count_min_sketch #(.ROWS(ROWS), .ROW_LEN(ROW_LEN)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .key(key),
    .out_valid(out_valid), .out_stall(out_stall), .estimate(estimate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sketch_board board = new();

  // pacing knobs, changed per phase; the long hold is requested by the main flow
  bit    in_idle   = 1'b1;
  bit    out_idle  = 1'b1;
  bit    hold_long = 1'b0;
  int    cycle_count = 0;
  key_t  key_pool [16];

  initial begin
    forever #1 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // estimate side: random stall before each word, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = out_idle ? $urandom_range(0, 9) : 0;
      if (hold_long) begin
        // counted in this process while the sender keeps pushing queries
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_estimate(estimate);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // offer one word after a random gap, hold it until taken
  task automatic send_word(logic rt, key_t k);
    int gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rt;
    key      = k;
    do @(posedge clk); while (in_stall);
    board.note_word(rt, k);
  endtask

  // no words in flight and no estimates owed before the registers change
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.estimates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(int idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(4 * idx);
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_coef(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_coef(int idx);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_W'(4 * idx);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== board.coef_value(idx)) begin
      $display("%0t: register %0d readback, expected %0h, got %0h",
               $time, idx, board.coef_value(idx), prdata);
      board.mismatches++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main flow
  // --------------------------------------------------------------------------
  initial begin
    coef_t coef;
    int    n_words;
    logic  rt;
    key_t  k;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset coefficients: key extremes, alternating bit patterns,
    // a key never counted, repeated adds of one key
    send_word(REQ_QUERY, 32'h0000_0000);
    send_word(REQ_ADD,   32'h0000_0000);
    send_word(REQ_ADD,   32'hFFFF_FFFF);
    send_word(REQ_ADD,   32'hFFFF_FFFF);
    send_word(REQ_QUERY, 32'h0000_0000);
    send_word(REQ_QUERY, 32'hFFFF_FFFF);
    send_word(REQ_QUERY, 32'h0001_2345);
    repeat (3) send_word(REQ_ADD, 32'h0000_0000);
    send_word(REQ_QUERY, 32'h0000_0000);
    send_word(REQ_ADD,   32'hAAAA_AAAA);
    send_word(REQ_ADD,   32'h5555_5555);
    send_word(REQ_ADD,   32'h5555_5555);
    send_word(REQ_QUERY, 32'hAAAA_AAAA);
    send_word(REQ_QUERY, 32'h5555_5555);
    send_word(REQ_QUERY, 32'h0000_0001);
    send_word(REQ_QUERY, 32'h8000_0000);
    // back to back, no gaps
    in_idle = 1'b0;
    send_word(REQ_ADD,   32'h8000_0000);
    send_word(REQ_QUERY, 32'h8000_0000);
    send_word(REQ_ADD,   32'h8000_0000);
    send_word(REQ_QUERY, 32'h8000_0000);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      // coefficient sets: all zero (every key collides), all ones, 9999999, then
      // random ones; every written word carries junk in its upper bits
      for (int i = 0; i < NUM_REGS; i++) begin
        case (p)
          0: coef = '0;
          1: coef = '1;
          2: coef = COEF_W'(9999999);
          default: begin
            if ($urandom_range(0, 3) == 0) coef = COEF_W'($urandom_range(0, 15));
            else coef = COEF_W'($urandom);
          end
        endcase
        write_coef(i, {8'($urandom), coef});
      end
      for (int i = 0; i < NUM_REGS; i++) read_coef(i);

      // pacing for this phase: gaps on both sides, none at all, or random
      case (p)
        0: begin
          in_idle  = 1'b1;
          out_idle = 1'b1;
        end
        4: begin
          in_idle  = 1'b0;
          out_idle = 1'b0;
        end
        default: begin
          in_idle  = $urandom_range(0, 3) != 0;
          out_idle = $urandom_range(0, 3) != 0;
        end
      endcase

      // small key pool so counters build up, plus fresh random keys
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 16; i++) key_pool[i] = $urandom;

      n_words = 310;
      for (int i = 0; i < n_words; i++) begin
        if (p == 3 && i == 150) begin
          // long stall on the estimate side while queries keep coming
          hold_long = 1'b1;
          in_idle   = 1'b0;
          for (int j = 0; j < 40; j++)
            send_word(REQ_QUERY, key_pool[$urandom_range(0, 15)]);
          in_idle = 1'b1;
        end
        rt = ($urandom_range(0, 9) < 6) ? REQ_ADD : REQ_QUERY;
        k  = ($urandom_range(0, 4) == 0) ? key_t'($urandom)
                                         : key_pool[$urandom_range(0, 15)];
        send_word(rt, k);
      end
    end

    wait_idle();
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### count_min_sketch.f
hdl/cms_pkg.sv
hdl/cms_ram.sv
hdl/cms_front.sv
hdl/cms_queue.sv
hdl/cms_back.sv
hdl/count_min_sketch.sv
dv/tb.sv
